/* sv/saq_pkg.sv */
// Shared widths and the item record that travels down the shortest-arc pipeline.
package saq_pkg;

    localparam int IN_WIDTH      = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int OUT_WIDTH     = 16;

    localparam int PROD_W = 2 * IN_WIDTH;        // signed products of two components
    localparam int LEN_W  = 2 * IN_WIDTH;        // squared length, unsigned
    localparam int CRS_W  = 2 * IN_WIDTH + 1;    // cross product component, signed
    localparam int DOT_W  = 2 * IN_WIDTH + 2;    // dot product, signed
    localparam int MAG_W  = 2 * IN_WIDTH + 1;    // magnitude of w or a cross component
    localparam int RT_W   = MAG_W + 1;           // square root width
    localparam int RAD_W  = 2 * RT_W;            // radicand width
    localparam int QW     = OUT_FRAC_BITS + 1;   // quotient bits
    localparam int NUM_W  = RT_W + OUT_FRAC_BITS + 2;

    localparam int IN_DATA_W  = ((6 * IN_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((4 * OUT_WIDTH + 7) / 8) * 8;

    typedef struct packed {
        logic                          vld;
        logic                          ident;
        logic                          opp;
        logic signed [CRS_W-1:0]       cx;
        logic signed [CRS_W-1:0]       cy;
        logic signed [CRS_W-1:0]       cz;
        logic signed [DOT_W-1:0]       d;
        logic [RAD_W-1:0]              sq_x;
        logic [RT_W-1:0]               sq_root;
        logic [RT_W+1:0]               sq_rem;
        logic [3:0][MAG_W-1:0]         mag;    // w, |cx|, |cy|, |cz|
        logic [3:0]                    neg;
        logic [NUM_W-1:0]              dv;
        logic [3:0][NUM_W-1:0]         rem;
        logic [3:0][QW-1:0]            q;
    } t_item;

endpackage

/* sv/saq_sqrt_cell.sv */
// One cell of the square root chain: resolves one root bit per stage.
module saq_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  saq_pkg::t_item i_item,
    output saq_pkg::t_item o_item
);

    saq_pkg::t_item r_item;
    saq_pkg::t_item n_item;
    logic [saq_pkg::RT_W+3:0] tmp;
    logic [saq_pkg::RT_W+3:0] trial;

    always_comb begin
        n_item = i_item;
        tmp    = {i_item.sq_rem, i_item.sq_x[saq_pkg::RAD_W-1 -: 2]};
        trial  = (saq_pkg::RT_W+4)'({i_item.sq_root, 2'b01});
        n_item.sq_x = {i_item.sq_x[saq_pkg::RAD_W-3:0], 2'b00};
        if (tmp >= trial) begin
            n_item.sq_rem  = (saq_pkg::RT_W+2)'(tmp - trial);
            n_item.sq_root = {i_item.sq_root[saq_pkg::RT_W-2:0], 1'b1};
        end else begin
            n_item.sq_rem  = tmp[saq_pkg::RT_W+1:0];
            n_item.sq_root = {i_item.sq_root[saq_pkg::RT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

/* sv/saq_div_cell.sv */
// One cell of the divider chain: one quotient bit for all four lanes per stage.
module saq_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  saq_pkg::t_item i_item,
    output saq_pkg::t_item o_item
);

    saq_pkg::t_item r_item;
    saq_pkg::t_item n_item;

    always_comb begin
        n_item    = i_item;
        n_item.dv = i_item.dv >> 1;
        for (int l = 0; l < 4; l++) begin
            if (i_item.rem[l] >= i_item.dv) begin
                n_item.rem[l] = i_item.rem[l] - i_item.dv;
                n_item.q[l]   = {i_item.q[l][saq_pkg::QW-2:0], 1'b1};
            end else begin
                n_item.q[l]   = {i_item.q[l][saq_pkg::QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

/* sv/saq_front.sv */
// Front end: products, lengths, cross and dot products, special cases, |a|^2 |b|^2.
module saq_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic [saq_pkg::IN_DATA_W-1:0]    i_data,
    output saq_pkg::t_item                   o_item
);

    localparam int N  = saq_pkg::IN_WIDTH;
    localparam int PW = saq_pkg::PROD_W;

    logic signed [N-1:0] ax, ay, az, bx, by, bz;
    assign ax = i_data[0*N +: N];
    assign ay = i_data[1*N +: N];
    assign az = i_data[2*N +: N];
    assign bx = i_data[3*N +: N];
    assign by = i_data[4*N +: N];
    assign bz = i_data[5*N +: N];

    // stage 1: all products
    logic                 r_v1;
    logic signed [PW-1:0] r_aa [3];
    logic signed [PW-1:0] r_bb [3];
    logic signed [PW-1:0] r_cp [6];
    logic signed [PW-1:0] r_dp [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_aa[0] <= ax * ax;  r_aa[1] <= ay * ay;  r_aa[2] <= az * az;
            r_bb[0] <= bx * bx;  r_bb[1] <= by * by;  r_bb[2] <= bz * bz;
            r_cp[0] <= ay * bz;  r_cp[1] <= az * by;
            r_cp[2] <= az * bx;  r_cp[3] <= ax * bz;
            r_cp[4] <= ax * by;  r_cp[5] <= ay * bx;
            r_dp[0] <= ax * bx;  r_dp[1] <= ay * by;  r_dp[2] <= az * bz;
        end
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
        end
    end

    // stage 2: sums and special cases
    logic                                r_v2;
    logic [saq_pkg::LEN_W-1:0]           r_la, r_lb;
    logic signed [saq_pkg::CRS_W-1:0]    r_cx, r_cy, r_cz;
    logic signed [saq_pkg::DOT_W-1:0]    r_d;
    logic                                r_ident2, r_opp2;
    logic [saq_pkg::LEN_W-1:0]           n_la, n_lb;
    logic signed [saq_pkg::CRS_W-1:0]    n_cx, n_cy, n_cz;
    logic signed [saq_pkg::DOT_W-1:0]    n_d;
    logic                                zl, opp;

    always_comb begin
        n_la = saq_pkg::LEN_W'(r_aa[0]) + saq_pkg::LEN_W'(r_aa[1]) + saq_pkg::LEN_W'(r_aa[2]);
        n_lb = saq_pkg::LEN_W'(r_bb[0]) + saq_pkg::LEN_W'(r_bb[1]) + saq_pkg::LEN_W'(r_bb[2]);
        n_cx = saq_pkg::CRS_W'(r_cp[0]) - saq_pkg::CRS_W'(r_cp[1]);
        n_cy = saq_pkg::CRS_W'(r_cp[2]) - saq_pkg::CRS_W'(r_cp[3]);
        n_cz = saq_pkg::CRS_W'(r_cp[4]) - saq_pkg::CRS_W'(r_cp[5]);
        n_d  = saq_pkg::DOT_W'(r_dp[0]) + saq_pkg::DOT_W'(r_dp[1])
             + saq_pkg::DOT_W'(r_dp[2]);
        zl   = (n_la == '0) || (n_lb == '0);
        opp  = !zl && (n_cx == '0) && (n_cy == '0) && (n_cz == '0) && n_d[saq_pkg::DOT_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_la     <= n_la;
            r_lb     <= n_lb;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_cz     <= n_cz;
            r_d      <= n_d;
            r_ident2 <= zl || opp;
            r_opp2   <= opp;
        end
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    // stage 3: product of squared lengths, seeds the root chain
    saq_pkg::t_item                r_item;
    saq_pkg::t_item                n_item;
    logic [2*saq_pkg::LEN_W-1:0]   lprod;

    always_comb begin
        lprod          = r_la * r_lb;
        n_item         = '0;
        n_item.vld     = r_v2;
        n_item.ident   = r_ident2;
        n_item.opp     = r_opp2;
        n_item.cx      = r_cx;
        n_item.cy      = r_cy;
        n_item.cz      = r_cz;
        n_item.d       = r_d;
        n_item.sq_x    = saq_pkg::RAD_W'(lprod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

/* sv/shortest_arc_quaternion.sv */
// Top level: shortest-arc unit quaternion between two integer 3-vectors.
// Fully pipelined: one vector pair per clock while the output is not stalled. The depth
// is set by two square root chains of 34 cells (one root bit per cell) and a 15-cell
// divider chain (one quotient bit per cell) plus front and scaling stages. When a result
// waits at the output and the last stage holds an item, the whole pipeline holds; empty
// slots keep flowing. Zero-length inputs give the identity; antiparallel inputs give the
// identity with the opposite flag set.
module shortest_arc_quaternion (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [saq_pkg::IN_DATA_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [saq_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // opposite_flag
    output logic                            o_m_tuser
);

    localparam int F  = saq_pkg::OUT_FRAC_BITS;
    localparam int OW = saq_pkg::OUT_WIDTH;
    localparam int MW = saq_pkg::MAG_W;

    logic en;
    logic r_out_vld;
    saq_pkg::t_item last;

    assign en         = !last.vld || !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    saq_pkg::t_item ch_a [saq_pkg::RT_W+1];
    saq_pkg::t_item ch_b [saq_pkg::RT_W+1];
    saq_pkg::t_item ch_d [saq_pkg::QW+1];

    saq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_item  (ch_a[0])
    );

    for (genvar g = 0; g < saq_pkg::RT_W; g++) begin : g_sqa
        saq_sqrt_cell u_cell (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
            .i_item (ch_a[g]), .o_item (ch_a[g+1])
        );
    end

    // w = floor(sqrt(|a|^2 |b|^2)) + a.b, then magnitudes and signs
    saq_pkg::t_item r_t1, n_t1;
    logic signed [saq_pkg::DOT_W:0] wsum;

    always_comb begin
        n_t1   = ch_a[saq_pkg::RT_W];
        wsum   = $signed({1'b0, ch_a[saq_pkg::RT_W].sq_root[saq_pkg::RT_W-1:0]})
               + (saq_pkg::DOT_W+1)'(ch_a[saq_pkg::RT_W].d);
        n_t1.mag[0] = wsum[MW-1:0];
        n_t1.neg[0] = 1'b0;
        n_t1.neg[1] = n_t1.cx[saq_pkg::CRS_W-1];
        n_t1.neg[2] = n_t1.cy[saq_pkg::CRS_W-1];
        n_t1.neg[3] = n_t1.cz[saq_pkg::CRS_W-1];
        n_t1.mag[1] = n_t1.neg[1] ? MW'(-n_t1.cx) : MW'(n_t1.cx);
        n_t1.mag[2] = n_t1.neg[2] ? MW'(-n_t1.cy) : MW'(n_t1.cy);
        n_t1.mag[3] = n_t1.neg[3] ? MW'(-n_t1.cz) : MW'(n_t1.cz);
    end

    // squares of the four magnitudes
    saq_pkg::t_item    r_t2;
    logic [2*MW-1:0]   r_sq [4];

    // sum of squares seeds the second root chain
    saq_pkg::t_item r_t3, n_t3;

    always_comb begin
        n_t3         = r_t2;
        n_t3.sq_x    = saq_pkg::RAD_W'(r_sq[0]) + saq_pkg::RAD_W'(r_sq[1])
                     + saq_pkg::RAD_W'(r_sq[2]) + saq_pkg::RAD_W'(r_sq[3]);
        n_t3.sq_root = '0;
        n_t3.sq_rem  = '0;
    end

    assign ch_b[0] = r_t3;

    for (genvar g = 0; g < saq_pkg::RT_W; g++) begin : g_sqb
        saq_sqrt_cell u_cell (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
            .i_item (ch_b[g]), .o_item (ch_b[g+1])
        );
    end

    // divider setup: q = (|v| * 2^(F+1) + n) / (2n), rounds half away from zero
    saq_pkg::t_item r_t4, n_t4;
    logic [saq_pkg::RT_W-1:0] nr;

    always_comb begin
        n_t4 = ch_b[saq_pkg::RT_W];
        nr   = ch_b[saq_pkg::RT_W].sq_root;
        n_t4.dv = saq_pkg::NUM_W'({nr, 1'b0}) << (saq_pkg::QW - 1);
        for (int l = 0; l < 4; l++) begin
            n_t4.rem[l] = (saq_pkg::NUM_W'(n_t4.mag[l]) << (F + 1)) + saq_pkg::NUM_W'(nr);
            n_t4.q[l]   = '0;
        end
        if (nr == '0) begin
            n_t4.ident = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.vld <= 1'b0;
            r_t2.vld <= 1'b0;
            r_t3.vld <= 1'b0;
            r_t4.vld <= 1'b0;
        end else if (en) begin
            r_t1 <= n_t1;
            r_t2 <= r_t1;
            for (int l = 0; l < 4; l++) begin
                r_sq[l] <= r_t1.mag[l] * r_t1.mag[l];
            end
            r_t3 <= n_t3;
            r_t4 <= n_t4;
        end
    end

    assign ch_d[0] = r_t4;

    for (genvar g = 0; g < saq_pkg::QW; g++) begin : g_div
        saq_div_cell u_cell (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
            .i_item (ch_d[g]), .o_item (ch_d[g+1])
        );
    end

    assign last = ch_d[saq_pkg::QW];

    // output register
    logic [3:0][OW-1:0] r_quat, n_quat;
    logic               r_flag;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            n_quat[l] = last.neg[l] ? OW'(-OW'(last.q[l])) : OW'(last.q[l]);
        end
        if (last.ident) begin
            n_quat    = '0;
            n_quat[0] = OW'(1 << F);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && last.vld) begin
            r_quat <= n_quat;
            r_flag <= last.opp;
        end
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en && last.vld) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = saq_pkg::OUT_DATA_W'(r_quat);
    assign o_m_tuser  = r_flag;

endmodule

/* sim/tb_shortest_arc_quaternion.sv */
// Testbench for the shortest-arc quaternion block: random and directed vector pairs.
`timescale 1ns / 1ps

module tb_shortest_arc_quaternion;

    localparam int LATENCY   = 91;
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        logic               opp;
    } t_quat;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [saq_pkg::IN_DATA_W-1:0]   i_s_tdata = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [saq_pkg::OUT_DATA_W-1:0]  o_m_tdata;
    logic                            o_m_tuser;

    logic [saq_pkg::IN_DATA_W-1:0]   pairs_pending[$];
    t_quat                           quats_due[$];
    int                              err_cnt = 0;
    int                              cyc = 0;
    bit                              calm = 1'b0;     // no idling on either side
    bit                              drain_hold = 1'b0;
    bit                              hold_req = 1'b0;
    bit                              hold_taken = 1'b0;
    int                              rx_hold = 0;

    shortest_arc_quaternion i_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [127:0] isqrt128(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(logic signed [127:0] v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] unit_part(logic signed [127:0] v, int k,
                                                     logic [127:0] n);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (v < 0) ? -v : v;
        mag = mag >> k;
        q = ((mag << (saq_pkg::OUT_FRAC_BITS + 1)) + n) / (n << 1);
        return sat16((v < 0) ? -$signed(q) : $signed(q));
    endfunction

    function automatic t_quat arc_quat(logic [saq_pkg::IN_DATA_W-1:0] pr);
        logic signed [127:0] a[3], b[3], cx, cy, cz, d, w, m, la, lb;
        logic [127:0] n;
        t_quat q;
        int k;
        for (int i = 0; i < 3; i++) begin
            a[i] = $signed(pr[16*i +: 16]);
            b[i] = $signed(pr[16*(i+3) +: 16]);
        end
        q.w = 16'sd1 <<< saq_pkg::OUT_FRAC_BITS; q.x = 0; q.y = 0; q.z = 0; q.opp = 1'b0;
        la = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        lb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
        if (la == 0 || lb == 0) return q;
        cx = a[1]*b[2] - a[2]*b[1];
        cy = a[2]*b[0] - a[0]*b[2];
        cz = a[0]*b[1] - a[1]*b[0];
        d  = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
        if (cx == 0 && cy == 0 && cz == 0 && d < 0) begin
            q.opp = 1'b1;
            return q;
        end
        w = $signed(isqrt128(la * lb)) + d;
        m = (w < 0) ? -w : w;
        if ((cx < 0 ? -cx : cx) > m) m = cx < 0 ? -cx : cx;
        if ((cy < 0 ? -cy : cy) > m) m = cy < 0 ? -cy : cy;
        if ((cz < 0 ? -cz : cz) > m) m = cz < 0 ? -cz : cz;
        k = 0;
        while ((m >> k) >= (128'd1 << 62)) k++;
        n = isqrt128((((w < 0 ? -w : w) >> k) ** 2) + (((cx < 0 ? -cx : cx) >> k) ** 2)
                   + (((cy < 0 ? -cy : cy) >> k) ** 2) + (((cz < 0 ? -cz : cz) >> k) ** 2));
        if (n == 0) return q;
        q.w = unit_part(w, k, n);
        q.x = unit_part(cx, k, n);
        q.y = unit_part(cy, k, n);
        q.z = unit_part(cz, k, n);
        return q;
    endfunction

    function automatic logic [saq_pkg::IN_DATA_W-1:0] mk_pair(int ax, int ay, int az,
                                                              int bx, int by, int bz);
        return {bz[15:0], by[15:0], bx[15:0], az[15:0], ay[15:0], ax[15:0]};
    endfunction

    function automatic logic [15:0] rnd_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 6)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && !o_s_tready)) begin
        end else if (!drain_hold && pairs_pending.size() > 0
                     && (calm || $urandom_range(0, 99) >= 21)) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= pairs_pending.pop_front();
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready && i_rst_n)
            quats_due.push_back(arc_quat(i_s_tdata));
    end

    // receiver ready, with one long hold-off
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            rx_hold    <= 399;
            i_m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || $urandom_range(0, 99) >= 21;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_quat e;
        logic signed [15:0] gw, gx, gy, gz;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            {gz, gy, gx, gw} = o_m_tdata;
            if (quats_due.size() == 0) begin
                $display("%0t: result with nothing expected: %h %b", $time, o_m_tdata,
                         o_m_tuser);
                err_cnt++;
            end else begin
                e = quats_due.pop_front();
                if (gw !== e.w || gx !== e.x || gy !== e.y || gz !== e.z
                    || o_m_tuser !== e.opp) begin
                    $display("%0t: mismatch exp w=%0d x=%0d y=%0d z=%0d opp=%b", $time,
                             e.w, e.x, e.y, e.z, e.opp);
                    $display("%0t:          got w=%0d x=%0d y=%0d z=%0d opp=%b", $time,
                             gw, gx, gy, gz, o_m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= MAX_CYCLE) begin
            $display("tb_shortest_arc_quaternion: errors");
            $finish;
        end
    end

    initial begin
        int s;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, zero length, parallel, antiparallel
        pairs_pending.push_back(mk_pair(0, 0, 0, 5, 6, 7));
        pairs_pending.push_back(mk_pair(3, -2, 1, 0, 0, 0));
        pairs_pending.push_back(mk_pair(0, 0, 0, 0, 0, 0));
        pairs_pending.push_back(mk_pair(1, 0, 0, 1, 0, 0));
        pairs_pending.push_back(mk_pair(1, 0, 0, -1, 0, 0));
        pairs_pending.push_back(mk_pair(2, -4, 6, -1, 2, -3));
        pairs_pending.push_back(mk_pair(2, -4, 6, 3, -6, 9));
        pairs_pending.push_back(mk_pair(1, 0, 0, 0, 1, 0));
        pairs_pending.push_back(mk_pair(-32768, -32768, -32768, -32768, -32768, -32768));
        pairs_pending.push_back(mk_pair(-32768, -32768, -32768, 32767, 32767, 32767));
        pairs_pending.push_back(mk_pair(32767, 32767, 32767, 32767, 32767, 32767));
        pairs_pending.push_back(mk_pair(-32768, 0, 0, 32767, 0, 0));
        pairs_pending.push_back(mk_pair(-32768, 0, 0, 0, 32767, 0));
        pairs_pending.push_back(mk_pair(32767, -32768, 1, -32768, 32767, -1));
        pairs_pending.push_back(mk_pair(1, 1, 0, -32768, -32768, 0));
        pairs_pending.push_back(mk_pair(-32768, 32767, -32768, 32767, -32768, 32767));
        for (int i = 0; i < 1000; i++) begin
            logic [15:0] c[6];
            for (int j = 0; j < 6; j++) c[j] = rnd_comp();
            s = $urandom_range(0, 9);
            if (s == 0) begin                  // scaled copy, same or opposite direction
                s = $urandom_range(0, 3) - 2;
                if (s >= 0) s = s + 1;
                for (int j = 0; j < 3; j++) begin
                    c[j] = 16'($urandom_range(0, 4000)) - 16'd2000;
                    c[j + 3] = 16'($signed(c[j]) * s);
                end
            end else if (s == 1) begin
                for (int j = 0; j < 3; j++) c[j] = 0;
            end
            pairs_pending.push_back({c[5], c[4], c[3], c[2], c[1], c[0]});
            if (i == 300) begin
                // long receiver hold-off while the sender keeps pushing
                wait (pairs_pending.size() <= 700);
                hold_req = 1'b1;
            end
        end
        // run without idle until 850 pairs remain pending; rest random
        calm = 1'b1;
        wait (pairs_pending.size() <= 850);
        calm = 1'b0;
        wait (pairs_pending.size() <= 500);
        // sender pause until drained
        drain_hold = 1'b1;
        @(posedge i_clk);
        wait (quats_due.size() == 0 && !i_s_tvalid);
        drain_hold = 1'b0;
        wait (pairs_pending.size() == 0);
        @(posedge i_clk);
        wait (!i_s_tvalid);
        wait (quats_due.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_shortest_arc_quaternion: clean");
        end else begin
            $display("tb_shortest_arc_quaternion: errors");
        end
        $finish;
    end
endmodule
